### rtl/core/assert_macros.svh
// Assertion macros shared by the checker modules of the voice slot allocator.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/vsa_pkg.sv
// Shared types and constants of the voice slot allocator.
// Depends on nothing; used by the controller, the datapath and the top level.
package vsa_pkg;

  // Fixed widths of the channel fields.
  localparam int OP_W    = 2;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;

  // Operation codes of an input transfer.
  localparam logic [OP_W-1:0] OP_START    = 2'd0;
  localparam logic [OP_W-1:0] OP_FINISHED = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP_ALL = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT
  } vsa_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input transfer
    logic search;  // free-slot search and list match
    logic commit;  // update the pool and present the result
  } vsa_cmd_t;

endpackage

### rtl/core/vsa_ctrl.sv
// Sequencer of the voice slot allocator: accept, search step, commit step.
// Depends on vsa_pkg for the state type and the command struct.
module vsa_ctrl import vsa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output vsa_cmd_t cmd
);

  vsa_state_t state_r;
  vsa_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL:   state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Commands and the busy flag.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_EVAL:   cmd.search = 1'b1;
      ST_COMMIT: cmd.commit = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

endmodule

### rtl/core/vsa_datapath.sv
// Datapath of the voice slot allocator: busy bits, start-order list and result registers.
// Depends on vsa_pkg for field widths, operation codes and the command struct.
module vsa_datapath import vsa_pkg::*; #(
  parameter int NUM_VOICES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vsa_cmd_t           cmd,
  input  logic [OP_W-1:0]    in_op,
  input  logic [SLOT_W-1:0]  in_slot_id,
  output logic               out_valid,
  output logic [SLOT_W-1:0]  out_granted_slot,
  output logic               out_took_oldest,
  output logic               out_ignored,
  output logic [COUNT_W-1:0] out_active_count
);

  localparam int IW = $clog2(NUM_VOICES);
  localparam int LW = $clog2(NUM_VOICES + 1);
  localparam int CW = (IW > SLOT_W) ? IW : SLOT_W;

  // Captured transfer.
  logic [OP_W-1:0]   op_r;
  logic [SLOT_W-1:0] sid_r;

  // Pool state.
  logic [NUM_VOICES-1:0] busy_bits_r, busy_bits_nxt;
  logic [IW-1:0]         order_r   [NUM_VOICES];
  logic [IW-1:0]         order_nxt [NUM_VOICES];
  logic [LW-1:0]         len_r, len_nxt;

  // Search results.
  logic                  free_found_r, free_found_nxt;
  logic [IW-1:0]         free_idx_r, free_idx_nxt;
  logic [NUM_VOICES-1:0] match_r, match_nxt;
  logic                  sid_busy_r, sid_busy_nxt;

  // Result registers.
  logic               out_valid_r;
  logic [SLOT_W-1:0]  granted_r, granted_nxt;
  logic               stole_r, stole_nxt;
  logic               ign_r, ign_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  // Slot number from the transfer, checked against the pool size.
  logic [CW-1:0] sid_ext;
  logic          sid_in_range;
  logic [IW-1:0] sid_idx;

  assign sid_ext      = CW'(sid_r);
  assign sid_in_range = {1'b0, sid_ext} < (CW + 1)'(NUM_VOICES);
  assign sid_idx      = sid_ext[IW-1:0];

  // Search step: lowest free slot, busy state of the named slot, list match.
  always_comb begin
    free_found_nxt = 1'b0;
    free_idx_nxt   = '0;
    for (int i = NUM_VOICES - 1; i >= 0; i--) begin
      if (!busy_bits_r[i]) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = IW'(i);
      end
    end
    sid_busy_nxt = sid_in_range && busy_bits_r[sid_idx];
    for (int i = 0; i < NUM_VOICES; i++) begin
      match_nxt[i] = (LW'(i) < len_r) && (CW'(order_r[i]) == sid_ext);
    end
  end

  // Commit step: decode the operation.
  logic                  is_start, is_finished, is_stop;
  logic                  steal;
  logic [IW-1:0]         granted;
  logic [NUM_VOICES-1:0] shift_mask;
  logic                  removed;
  logic [LW-1:0]         len_pre;
  logic                  append;

  assign is_start    = (op_r == OP_START);
  assign is_finished = (op_r == OP_FINISHED);
  assign is_stop     = (op_r == OP_STOP_ALL);
  assign steal       = is_start && !free_found_r;

  always_comb begin
    if (free_found_r) begin
      granted = free_idx_r;
    end else if (len_r != '0) begin
      granted = order_r[0];
    end else begin
      granted = '0;
    end
  end

  // Entries at and above the removed position take their upper neighbor.
  always_comb begin
    for (int i = 0; i < NUM_VOICES; i++) begin
      if (steal) begin
        shift_mask[i] = (len_r != '0);
      end else if (is_finished && sid_busy_r) begin
        shift_mask[i] = |(match_r << (NUM_VOICES - 1 - i));
      end else begin
        shift_mask[i] = 1'b0;
      end
    end
  end

  assign removed = shift_mask[NUM_VOICES-1];
  assign len_pre = removed ? (len_r - LW'(1)) : len_r;
  assign append  = is_start && (len_pre < LW'(NUM_VOICES));

  // Next list contents and length.
  always_comb begin
    int nb;
    for (int i = 0; i < NUM_VOICES; i++) begin
      nb = (i < NUM_VOICES - 1) ? i + 1 : i;
      order_nxt[i] = shift_mask[i] ? order_r[nb] : order_r[i];
      if (append && (LW'(i) == len_pre)) begin
        order_nxt[i] = granted;
      end
    end
    if (is_stop) begin
      len_nxt = '0;
    end else if (append) begin
      len_nxt = len_pre + LW'(1);
    end else begin
      len_nxt = len_pre;
    end
  end

  // Next busy bits.
  always_comb begin
    busy_bits_nxt = busy_bits_r;
    for (int i = 0; i < NUM_VOICES; i++) begin
      if (is_start && (IW'(i) == granted)) begin
        busy_bits_nxt[i] = 1'b1;
      end
      if (is_finished && sid_busy_r && (IW'(i) == sid_idx)) begin
        busy_bits_nxt[i] = 1'b0;
      end
    end
    if (is_stop) begin
      busy_bits_nxt = '0;
    end
  end

  // Result fields, cut to their port widths.
  logic [SLOT_W+IW-1:0]  granted_wide;
  logic [COUNT_W+LW-1:0] count_wide;

  assign granted_wide = {{SLOT_W{1'b0}}, granted};
  assign count_wide   = {{COUNT_W{1'b0}}, len_nxt};
  assign granted_nxt  = is_start ? granted_wide[SLOT_W-1:0] : '0;
  assign stole_nxt    = steal;
  assign ign_nxt      = is_finished && !sid_busy_r;
  assign count_nxt    = count_wide[COUNT_W-1:0];

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_bits_r <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
      if (cmd.commit) begin
        busy_bits_r <= busy_bits_nxt;
        len_r       <= len_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      sid_r <= in_slot_id;
    end
    if (cmd.search) begin
      free_found_r <= free_found_nxt;
      free_idx_r   <= free_idx_nxt;
      match_r      <= match_nxt;
      sid_busy_r   <= sid_busy_nxt;
    end
    if (cmd.commit) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        order_r[i] <= order_nxt[i];
      end
      granted_r <= granted_nxt;
      stole_r   <= stole_nxt;
      ign_r     <= ign_nxt;
      count_r   <= count_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = granted_r;
  assign out_took_oldest  = stole_r;
  assign out_ignored      = ign_r;
  assign out_active_count = count_r;

endmodule

### rtl/core/voice_slot_allocator_unit.sv
// Top level of the voice slot allocator: sequencer plus datapath.
// Depends on vsa_pkg, vsa_ctrl and vsa_datapath.
//
//   Channel   Handshake           Ports
//   input     start & !busy       in_op, in_slot_id
//   result    out_valid strobe    out_granted_slot, out_took_oldest, out_ignored,
//                                 out_active_count
//
// Each operation runs inside as a search step (lowest free slot and
// the list match) and a commit step that updates the busy bits and compacts the list.
// The result strobe is high once the commit step is registered, in the idle state;
// busy is low in that cycle, so a new transfer can be accepted at the edge that
// ends it; no new transfer is taken while an operation is in its steps.
// Reset is synchronous and clears the busy bits and the list length.
// The receiver cannot stall; each result stands for exactly one cycle.
module voice_slot_allocator_unit import vsa_pkg::*; #(
  parameter int NUM_VOICES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_op,
  input  logic [SLOT_W-1:0]  in_slot_id,
  output logic               out_valid,
  output logic [SLOT_W-1:0]  out_granted_slot,
  output logic               out_took_oldest,
  output logic               out_ignored,
  output logic [COUNT_W-1:0] out_active_count
);

  vsa_cmd_t cmd;

  // Sequencer.
  vsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Pool state and result registers.
  vsa_datapath #(
    .NUM_VOICES (NUM_VOICES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_op            (in_op),
    .in_slot_id       (in_slot_id),
    .out_valid        (out_valid),
    .out_granted_slot (out_granted_slot),
    .out_took_oldest  (out_took_oldest),
    .out_ignored      (out_ignored),
    .out_active_count (out_active_count)
  );

endmodule

### rtl/core/vsa_checker.sv
// Port-level checker of the voice slot allocator, bound to the top level.
// Depends on vsa_pkg for field widths and on assert_macros.svh.
`include "assert_macros.svh"

module vsa_checker import vsa_pkg::*; #(
  parameter int NUM_VOICES = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [SLOT_W-1:0]  out_granted_slot,
  input logic               out_took_oldest,
  input logic               out_ignored,
  input logic [COUNT_W-1:0] out_active_count
);

  // An accepted transfer gives its result strobe once the search and commit steps are done.
  `ASSERT_CLK(a_result_latency, clk, rst_n, (start && !busy) |-> ##3 out_valid, "result missing")

  // A result only appears after a transfer was in work.
  `ASSERT_CLK(a_result_after_busy, clk, rst_n, $rose(out_valid) |-> $past(busy), "unexpected result")

  // The block is ready again while its result is shown.
  `ASSERT_NEVER(a_ready_with_result, clk, rst_n, out_valid && busy, "busy during result")

  // A stolen slot and an ignored finish never come from one operation.
  `ASSERT_NEVER(a_flag_clash, clk, rst_n, out_valid && out_took_oldest && out_ignored,
                "conflicting flags")

  // An ignored finish grants nothing.
  `ASSERT_CLK(a_ignored_no_grant, clk, rst_n,
              (out_valid && out_ignored) |-> (out_granted_slot == '0), "grant on ignore")

  // A steal only happens on a full pool, which stays full afterwards.
  `ASSERT_CLK(a_steal_full_pool, clk, rst_n,
              (out_valid && out_took_oldest) |-> (out_active_count == COUNT_W'(NUM_VOICES)),
              "steal without a full pool")

endmodule

bind voice_slot_allocator_unit vsa_checker #(
  .NUM_VOICES (NUM_VOICES)
) u_vsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_granted_slot (out_granted_slot),
  .out_took_oldest  (out_took_oldest),
  .out_ignored      (out_ignored),
  .out_active_count (out_active_count)
);

### tb/tb_voice_slot_allocator_unit.sv
// Self-checking testbench for voice_slot_allocator_unit: directed and random transfers,
// each result checked against an in-bench model of the slot pool and its age list.
// Depends on vsa_pkg and the voice_slot_allocator_unit RTL.
module tb_voice_slot_allocator_unit;
  import vsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_VOICES  = 16;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_TICKS = 8;
  localparam int RANDOM_ITEMS = 800;

  // The fourth op code has no meaning in the block.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [SLOT_W-1:0]  granted_slot;
    logic               took_oldest;
    logic               ignored;
    logic [COUNT_W-1:0] active_count;
  } voice_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [OP_W-1:0]    in_op;
  logic [SLOT_W-1:0]  in_slot_id;
  logic               out_valid;
  logic [SLOT_W-1:0]  out_granted_slot;
  logic               out_took_oldest;
  logic               out_ignored;
  logic [COUNT_W-1:0] out_active_count;

  // Model of the pool: busy bits and the busy slots listed oldest first.
  logic [NUM_VOICES-1:0] pool_busy;
  logic [SLOT_W-1:0]     age_list[$];

  voice_result_t pending_results[$];
  int            error_count;
  int            cycle_count;
  bit            sender_gaps;

  voice_slot_allocator_unit #(
    .NUM_VOICES(NUM_VOICES)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_slot_id       (in_slot_id),
    .out_valid        (out_valid),
    .out_granted_slot (out_granted_slot),
    .out_took_oldest  (out_took_oldest),
    .out_ignored      (out_ignored),
    .out_active_count (out_active_count)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("voice_slot_allocator_unit test failed");
      $finish;
    end
  end

  // Apply one transfer to the pool model and return what the block should report.
  function automatic voice_result_t allocate_voice(logic [OP_W-1:0] op,
                                                   logic [SLOT_W-1:0] sid);
    voice_result_t res;
    bit            found;
    res   = '0;
    found = 1'b0;
    case (op)
      OP_START: begin
        for (int s = 0; s < NUM_VOICES; s++) begin
          if (!pool_busy[s]) begin
            res.granted_slot = SLOT_W'(s);
            found = 1'b1;
            break;
          end
        end
        // Pool full: the oldest voice is stolen and moves to the newest end.
        if (!found) begin
          res.took_oldest = 1'b1;
          if (age_list.size() > 0)
            res.granted_slot = age_list.pop_front();
          else
            res.granted_slot = '0;
        end
        pool_busy[res.granted_slot] = 1'b1;
        if (age_list.size() < NUM_VOICES)
          age_list.push_back(res.granted_slot);
      end
      OP_FINISHED: begin
        if (int'(sid) >= NUM_VOICES || !pool_busy[sid]) begin
          res.ignored = 1'b1;
        end else begin
          pool_busy[sid] = 1'b0;
          for (int i = 0; i < age_list.size(); i++) begin
            if (age_list[i] == sid) begin
              age_list.delete(i);
              break;
            end
          end
        end
      end
      OP_STOP_ALL: begin
        pool_busy = '0;
        age_list.delete();
      end
      default: begin
      end
    endcase
    res.active_count = COUNT_W'(age_list.size());
    return res;
  endfunction

  // Send one transfer after an optional random gap; predict it when accepted.
  task automatic send_transfer(logic [OP_W-1:0] op, logic [SLOT_W-1:0] sid);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_op      <= op;
    in_slot_id <= sid;
    do begin
      @(posedge clk);
    end while (busy);
    pending_results.push_back(allocate_voice(op, sid));
  endtask

  task automatic compare_field(string name, int expected, int actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      error_count++;
    end
  endtask

  // Every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    voice_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: granted_slot %0d, active_count %0d",
               out_granted_slot, out_active_count);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        compare_field("granted_slot", exp_res.granted_slot, out_granted_slot);
        compare_field("took_oldest", exp_res.took_oldest, out_took_oldest);
        compare_field("ignored", exp_res.ignored, out_ignored);
        compare_field("active_count", exp_res.active_count, out_active_count);
      end
    end
  end

  // Fill the pool from slot 0 upward, then steal the oldest voice once.
  task automatic test_fill_and_steal();
    for (int i = 0; i <= NUM_VOICES; i++)
      send_transfer(OP_START, SLOT_W'($urandom_range(0, 15)));
  endtask

  // Free a busy slot in the middle of the list, repeat it while idle, free a second slot, refill the lower gap.
  task automatic test_finish_and_ignore();
    send_transfer(OP_FINISHED, 4'd5);
    send_transfer(OP_FINISHED, 4'd5);
    send_transfer(OP_FINISHED, 4'd15);
    send_transfer(OP_START, 4'd15);
  endtask

  // Unused op code on a pool with one slot free, then stop all and the idle cases after it.
  task automatic test_stop_all_and_unused();
    send_transfer(OP_UNUSED, 4'd10);
    send_transfer(OP_STOP_ALL, 4'd15);
    send_transfer(OP_FINISHED, 4'd0);
    send_transfer(OP_START, 4'd0);
  endtask

  // Mostly well-formed traffic with phases that lean toward starts or finishes.
  task automatic test_random_traffic();
    int start_bias;
    int roll;
    start_bias = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: start_bias = 20;
          1: start_bias = 50;
          default: start_bias = 80;
        endcase
        sender_gaps = ($urandom_range(0, 3) != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 3)
        send_transfer(OP_STOP_ALL, SLOT_W'($urandom_range(0, 15)));
      else if (roll < 8)
        send_transfer(OP_UNUSED, SLOT_W'($urandom_range(0, 15)));
      else if (roll < 16)
        send_transfer(OP_FINISHED, SLOT_W'($urandom_range(0, 15)));
      else if (roll < 16 + start_bias * 84 / 100 || age_list.size() == 0)
        send_transfer(OP_START, SLOT_W'($urandom_range(0, 15)));
      else
        send_transfer(OP_FINISHED, age_list[$urandom_range(0, age_list.size() - 1)]);
    end
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    pool_busy   = '0;
    sender_gaps = 1'b0;
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_op      <= OP_START;
    in_slot_id <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_and_steal();
    sender_gaps = 1'b1;
    test_finish_and_ignore();
    test_stop_all_and_unused();
    test_random_traffic();
    start <= 1'b0;

    // Drain the outstanding results, then idle before the final report.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);

    if (error_count == 0)
      $display("voice_slot_allocator_unit test passed");
    else
      $display("voice_slot_allocator_unit test failed");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/vsa_pkg.sv
rtl/core/vsa_ctrl.sv
rtl/core/vsa_datapath.sv
rtl/core/voice_slot_allocator_unit.sv
rtl/core/vsa_checker.sv
tb/tb_voice_slot_allocator_unit.sv
